FILE: rtl/core/sha256_stream_hasher_unit_assert.svh
// Assertion macros for the SHA-256 stream hasher.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define SHA256SH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 stream hasher: implication check failed");

`define SHA256SH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 stream hasher: next-cycle check failed");

`else

`define SHA256SH_ASSERT_IMP(lbl, ante, cons)

`define SHA256SH_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/sha256sh_pkg.sv
`default_nettype none

package sha256sh_pkg;

    localparam int SHA256SH_QUEUE_DEPTH = 4;

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;

    // One 32-bit message word on its way from the front end to the round engine.
    typedef struct packed {
        logic        valid;
        logic        msg_done;
        logic [31:0] word;
    } q_word_t;

    typedef enum logic [1:0] {
        FRONT_TAKE,
        FRONT_MARK,
        FRONT_ZERO,
        FRONT_LEN_LO
    } front_state_t;

    typedef enum logic [1:0] {
        BACK_ROUND,
        BACK_ADD,
        BACK_EMIT
    } back_state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha256sh_front.sv
`default_nettype none

module sha256sh_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // data_byte
    input  wire logic                  s_axis_tuser,  // byte_valid
    input  wire logic                  s_axis_tlast,  // message_end
    input  wire logic                  q_full,
    output sha256sh_pkg::q_word_t      q_push
);
    import sha256sh_pkg::*;

    front_state_t state_reg, state_next;
    logic [23:0]  acc_reg, acc_next;
    logic [1:0]   lane_reg, lane_next;
    logic [3:0]   widx_reg, widx_next;
    logic [60:0]  count_reg, count_next;
    logic         take;
    logic [31:0]  mark_word;

    assign s_axis_tready = (state_reg == FRONT_TAKE) && !q_full;
    assign take = s_axis_tvalid && s_axis_tready;

    // Bytes already held in the partial word are followed by the 0x80 marker.
    always_comb
    begin
        unique case (lane_reg)
            2'd0: mark_word = {PAD_MARK, 24'h0};
            2'd1: mark_word = {acc_reg[7:0], PAD_MARK, 16'h0};
            2'd2: mark_word = {acc_reg[15:0], PAD_MARK, 8'h0};
            default: mark_word = {acc_reg, PAD_MARK};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next = acc_reg;
        lane_next = lane_reg;
        widx_next = widx_reg;
        count_next = count_reg;
        q_push = '0;
        unique case (state_reg)
            FRONT_TAKE:
            begin
                if (take)
                begin
                    if (s_axis_tuser)
                    begin
                        count_next = count_reg + 61'd1;
                        acc_next = {acc_reg[15:0], s_axis_tdata};
                        lane_next = lane_reg + 2'd1;
                        if (lane_reg == 2'd3)
                        begin
                            q_push.valid = 1'b1;
                            q_push.word = {acc_reg, s_axis_tdata};
                            widx_next = widx_reg + 4'd1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = FRONT_MARK;
                    end
                end
            end
            FRONT_MARK:
            begin
                if (!q_full)
                begin
                    q_push.valid = 1'b1;
                    q_push.word = mark_word;
                    widx_next = widx_reg + 4'd1;
                    lane_next = 2'd0;
                    state_next = FRONT_ZERO;
                end
            end
            FRONT_ZERO:
            begin
                // Zero words run on, into a further block if need be, until the
                // length can take the last two words of a block.
                if (!q_full)
                begin
                    q_push.valid = 1'b1;
                    widx_next = widx_reg + 4'd1;
                    if (widx_reg == LEN_HI_WORD)
                    begin
                        q_push.word = count_reg[60:29];
                        state_next = FRONT_LEN_LO;
                    end
                end
            end
            FRONT_LEN_LO:
            begin
                if (!q_full)
                begin
                    q_push.valid = 1'b1;
                    q_push.msg_done = 1'b1;
                    q_push.word = {count_reg[28:0], 3'b000};
                    widx_next = 4'd0;
                    count_next = '0;
                    state_next = FRONT_TAKE;
                end
            end
            default:
            begin
                state_next = FRONT_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_TAKE;
            lane_reg <= 2'd0;
            widx_reg <= 4'd0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg <= lane_next;
            widx_reg <= widx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha256sh_queue.sv
`default_nettype none

module sha256sh_queue #(
    parameter int DEPTH = sha256sh_pkg::SHA256SH_QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256sh_pkg::q_word_t push,
    output logic                       full,
    output sha256sh_pkg::q_word_t      head,
    input  wire logic                  pop
);
    import sha256sh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [32:0]   mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full = (fill_reg == CW'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.msg_done = mem[rd_ptr_reg][32];
    assign head.word = mem[rd_ptr_reg][31:0];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= {push.msg_done, push.word};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha256sh_back.sv
`default_nettype none
`include "sha256_stream_hasher_unit_assert.svh"

module sha256sh_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256sh_pkg::q_word_t q_head,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // digest_word
    output logic [2:0]                 m_axis_tuser,  // word_index
    output logic                       m_axis_tlast   // last_word
);
    import sha256sh_pkg::*;

    back_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic        done_reg, done_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic        early;
    logic        advance;
    logic [31:0] wt;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    assign early = (round_reg[5:4] == 2'b00);
    assign advance = (state_reg == BACK_ROUND) && (!early || q_head.valid);
    assign q_pop = (state_reg == BACK_ROUND) && early && q_head.valid;

    // The first sixteen rounds take their word straight from the queue; the
    // rest expand it from the sixteen-word window.
    assign wt = early ? q_head.word
                      : w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + ch + K_TABLE[round_reg] + wt;
    assign t2 = big_sigma0(v_reg[0]) + mj;

    assign m_axis_tvalid = (state_reg == BACK_EMIT);
    assign m_axis_tdata = hash_reg[0];
    assign m_axis_tuser = emit_idx_reg;
    assign m_axis_tlast = (emit_idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        emit_idx_next = emit_idx_reg;
        done_next = done_reg;
        w_next = w_reg;
        v_next = v_reg;
        hash_next = hash_reg;
        unique case (state_reg)
            BACK_ROUND:
            begin
                if (advance)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_next[i] = w_reg[i + 1];
                    end
                    w_next[15] = wt;
                    v_next[7] = v_reg[6];
                    v_next[6] = v_reg[5];
                    v_next[5] = v_reg[4];
                    v_next[4] = v_reg[3] + t1;
                    v_next[3] = v_reg[2];
                    v_next[2] = v_reg[1];
                    v_next[1] = v_reg[0];
                    v_next[0] = t1 + t2;
                    round_next = round_reg + 6'd1;
                    if (round_reg == 6'd15)
                    begin
                        done_next = q_head.msg_done;
                    end
                    if (round_reg == 6'd63)
                    begin
                        state_next = BACK_ADD;
                    end
                end
            end
            BACK_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                    v_next[i] = hash_reg[i] + v_reg[i];
                end
                if (done_reg)
                begin
                    emit_idx_next = 3'd0;
                    state_next = BACK_EMIT;
                end
                else
                begin
                    state_next = BACK_ROUND;
                end
            end
            BACK_EMIT:
            begin
                if (m_axis_tready)
                begin
                    // The digest words shift down past the output port.
                    for (int i = 0; i < 7; i++)
                    begin
                        hash_next[i] = hash_reg[i + 1];
                    end
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'd7)
                    begin
                        hash_next = IV_TABLE;
                        v_next = IV_TABLE;
                        done_next = 1'b0;
                        state_next = BACK_ROUND;
                    end
                end
            end
            default:
            begin
                state_next = BACK_ROUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_ROUND;
            round_reg <= 6'd0;
            emit_idx_reg <= 3'd0;
            done_reg <= 1'b0;
            hash_reg <= IV_TABLE;
            v_reg <= IV_TABLE;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            emit_idx_reg <= emit_idx_next;
            done_reg <= done_next;
            hash_reg <= hash_next;
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    `SHA256SH_ASSERT_NXT(a_add_after_last_round, advance && (round_reg == 6'd63), state_reg == BACK_ADD && round_reg == 6'd0)
    `SHA256SH_ASSERT_NXT(a_round_steps_by_one, advance && (round_reg != 6'd63), state_reg == BACK_ROUND && round_reg == $past(round_reg) + 6'd1)
    `SHA256SH_ASSERT_NXT(a_emit_end_restarts, m_axis_tvalid && m_axis_tready && m_axis_tlast, state_reg == BACK_ROUND && round_reg == 6'd0 && !done_reg)
    `SHA256SH_ASSERT_IMP(a_pop_only_early, q_pop, state_reg == BACK_ROUND && round_reg < 6'd16)

endmodule

`default_nettype wire

FILE: rtl/core/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher.
// Input channel s_axis: one message byte per transfer in tdata, tuser set when
// the byte is present, tlast set on the transfer that ends the message (the
// byte, if any, is absorbed first). Padding and the bit length are added here.
// Output channel m_axis: eight transfers per message, digest words H0 to H7 in
// tdata, the word index in tuser, tlast on the eighth word.
// Bytes are taken at one per cycle while the four-word queue between the byte
// packer and the round engine has room. The packer makes a word from every four
// bytes, and the first sixteen rounds of a block wait on it; during the other 48
// rounds and the hash update, the queue fills and the input stalls.
// After the ending transfer the packer issues three to eighteen padding words
// and takes no input meanwhile.
// The digest words come straight from the hash registers and hold while the
// receiver stalls; the packer keeps accepting bytes until the queue fills.
// Reset loads the initial hash values and clears all counts; no clearing pass.
`default_nettype none

module sha256_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = sha256sh_pkg::SHA256SH_QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_valid
    input  wire logic        s_axis_tlast,   // message_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);
    import sha256sh_pkg::*;

    q_word_t push;
    q_word_t head;
    logic    q_full;
    logic    q_pop;

    sha256sh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (push)
    );

    sha256sh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (q_pop)
    );

    sha256sh_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
